// ----- rtl/core/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, codes and defaults of the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int OWNER_COUNT_DEF = 16;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_SET  = 2'd1;
  localparam logic [1:0] ACT_DEL  = 2'd2;

  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_EVT  = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic [1:0] MODE_CTR  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic [3:0]  owner;
    logic [7:0]  ident;
    logic [1:0]  mode;
    logic [14:0] period;
    logic [14:0] elapsed;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic take_ins;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_FIN  = 3'b100
  } state_t;

endpackage

// ----- rtl/core/ptt_if.sv -----
// ----------------------------------------------------------------------------
// ptt_if
// Input and result channels of the periodic timer table.
// ----------------------------------------------------------------------------
interface ptt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  owner;
  logic [7:0]  timer_id;
  logic [1:0]  fire_mode;
  logic signed [15:0] period;

  modport source (output valid, action, owner, timer_id, fire_mode, period, input ready);
  modport sink (input valid, action, owner, timer_id, fire_mode, period, output ready);
endinterface

interface ptt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        ok;
  logic [3:0]  event_owner;
  logic [7:0]  event_id;
  logic [1:0]  event_mode;
  logic [15:0] owner_count;
  logic        last;

  modport source (output valid, kind, ok, event_owner, event_id, event_mode, owner_count,
                  last, input ready);
  modport sink (input valid, kind, ok, event_owner, event_id, event_mode, owner_count,
                last, output ready);
endinterface

// ----- rtl/core/ptt_cell.sv -----
// ----------------------------------------------------------------------------
// ptt_cell
// One table slot: loads a new entry, or takes its neighbor's entry or the
// reinserted head entry while the table rotates.
// ----------------------------------------------------------------------------
module ptt_cell (
  input  logic               clk,
  input  logic               rst,
  input  ptt_pkg::cell_ctl_t ctl,
  input  ptt_pkg::entry_t    ld_entry,
  input  ptt_pkg::entry_t    nb_entry,
  input  logic               nb_used,
  input  ptt_pkg::entry_t    ins_entry,
  output ptt_pkg::entry_t    q,
  output logic               used
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q <= ctl.take_ins ? ins_entry : nb_entry;
    end else if (ctl.load) begin
      q <= ld_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctl.shift) begin
      used <= ctl.take_ins ? 1'b1 : nb_used;
    end else if (ctl.load) begin
      used <= 1'b1;
    end
  end

endmodule

// ----- rtl/core/ptt_ctr_mem.sv -----
// ----------------------------------------------------------------------------
// ptt_ctr_mem
// Per-owner event counters: one write and one registered read per cycle,
// zero until first written.
// ----------------------------------------------------------------------------
module ptt_ctr_mem #(
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata
);

  localparam int SIZE = 1 << AW;

  logic [15:0] mem [SIZE];
  logic [SIZE-1:0] vld;
  logic [15:0] rd_mem;
  logic        rd_vld;
  logic        byp;
  logic [15:0] byp_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_mem   <= mem[raddr];
    byp      <= we && (waddr == raddr);
    byp_data <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  assign rdata = byp ? byp_data : (rd_vld ? rd_mem : 16'd0);

endmodule

// ----- rtl/core/periodic_timer_table_top.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_table_top
// Ordered table of periodic timers kept in a row of slot cells that rotates
// as a queue while a tick or a delete walks it.
//
//   channel  dir  beat
//   in_ch    in   action, owner, timer_id, fire_mode, period
//   out_ch   out  kind, ok, event_owner, event_id, event_mode, owner_count, last
//
// Set, or tick/delete on an empty table: answered by one status beat. Tick or
// delete: the beat is taken, the queue rotates one step per used entry,
// then the final beat is issued.
// Reset is synchronous; the table empties and counters read zero at once.
// A stalled result holds the walk; the next beat is taken only when idle.
// ----------------------------------------------------------------------------
module periodic_timer_table_top #(
  parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF,
  parameter int OWNER_COUNT = ptt_pkg::OWNER_COUNT_DEF
) (
  input logic      clk,
  input logic      rst,
  ptt_in_if.sink   in_ch,
  ptt_out_if.source out_ch
);

  localparam int IW  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW  = $clog2(TIMER_SLOTS + 1);
  localparam int OAW = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1;

  ptt_pkg::entry_t    q      [TIMER_SLOTS];
  ptt_pkg::entry_t    nb     [TIMER_SLOTS];
  logic               used   [TIMER_SLOTS];
  logic               nb_used[TIMER_SLOTS];
  ptt_pkg::cell_ctl_t ctl    [TIMER_SLOTS];

  ptt_pkg::state_t state;
  logic [CW-1:0]   len;
  logic [CW-1:0]   steps;
  logic            op_del;
  logic            deleted;
  logic [3:0]      d_owner;
  logic [7:0]      d_id;

  logic        o_valid;
  logic        o_valid_next;
  logic [1:0]  o_kind;
  logic        o_ok;
  logic [3:0]  o_owner;
  logic [7:0]  o_id;
  logic [1:0]  o_mode;
  logic [15:0] o_cnt;
  logic        o_last;

  logic            adv;
  logic            acc;
  logic            pop;
  logic            set_ok;
  logic            o_set;
  ptt_pkg::entry_t ld_entry;
  ptt_pkg::entry_t head;
  ptt_pkg::entry_t ins_entry;
  ptt_pkg::entry_t next_head;
  logic            fire;
  logic            match;
  logic            keep;
  logic            emit;
  logic [CW-1:0]   lenm1;
  logic [8:0]      ow9;
  logic            has_ctr;
  logic [15:0]     ctr_rd;
  logic [15:0]     ctr_inc;
  logic            ctr_we;
  logic [8:0]      nh9;

  assign adv = !o_valid || out_ch.ready;
  assign in_ch.ready = (state == ptt_pkg::S_IDLE) && adv;
  assign acc = in_ch.valid && in_ch.ready;
  assign pop = (state == ptt_pkg::S_WALK) && adv;

  assign set_ok = acc && (in_ch.action == ptt_pkg::ACT_SET) && !in_ch.period[15] &&
                  (in_ch.period != 16'sd0) && (len != CW'(TIMER_SLOTS));

  assign ld_entry.owner   = in_ch.owner;
  assign ld_entry.ident   = in_ch.timer_id;
  assign ld_entry.mode    = in_ch.fire_mode;
  assign ld_entry.period  = in_ch.period[14:0];
  assign ld_entry.elapsed = 15'd1;

  assign head    = q[0];
  assign fire    = (head.elapsed == head.period);
  assign match   = op_del && !deleted && (head.owner == d_owner) && (head.ident == d_id);
  assign keep    = !match;
  assign lenm1   = len - CW'(1);
  assign ow9     = 9'(head.owner);
  assign has_ctr = (ow9 < 9'(OWNER_COUNT));
  assign ctr_inc = ctr_rd + 16'd1;
  assign emit    = !op_del && fire && (head.mode != ptt_pkg::MODE_NONE);
  assign ctr_we  = pop && !op_del && fire && (head.mode == ptt_pkg::MODE_CTR) && has_ctr;

  assign o_set = ((state == ptt_pkg::S_IDLE) && acc &&
                  ((in_ch.action == ptt_pkg::ACT_SET) ||
                   (((in_ch.action == ptt_pkg::ACT_DEL) ||
                     (in_ch.action == ptt_pkg::ACT_TICK)) && (len == '0)))) ||
                 (pop && emit) ||
                 ((state == ptt_pkg::S_FIN) && adv);
  assign o_valid_next = o_set || (o_valid && !out_ch.ready);

  always_comb begin
    ins_entry = head;
    if (!op_del) begin
      ins_entry.elapsed = fire ? 15'd1 : head.elapsed + 15'd1;
    end
  end

  always_comb begin
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (i < TIMER_SLOTS - 1) begin
        nb[i]      = q[i+1];
        nb_used[i] = used[i+1];
      end else begin
        nb[i]      = '0;
        nb_used[i] = 1'b0;
      end
      ctl[i].shift    = pop;
      ctl[i].take_ins = keep && (lenm1[IW-1:0] == IW'(i));
      ctl[i].load     = set_ok && (len == CW'(i));
    end
  end

  genvar g;
  generate
    for (g = 0; g < TIMER_SLOTS; g++) begin : g_cell
      ptt_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl[g]),
        .ld_entry (ld_entry),
        .nb_entry (nb[g]),
        .nb_used  (nb_used[g]),
        .ins_entry(ins_entry),
        .q        (q[g]),
        .used     (used[g])
      );
    end
  endgenerate

  always_comb begin
    if (pop) begin
      next_head = ctl[0].take_ins ? ins_entry : nb[0];
    end else begin
      next_head = head;
    end
  end
  assign nh9 = 9'(next_head.owner);

  ptt_ctr_mem #(
    .AW   (OAW)
  ) u_ctr_mem (
    .clk  (clk),
    .rst  (rst),
    .raddr(nh9[OAW-1:0]),
    .rdata(ctr_rd),
    .we   (ctr_we),
    .waddr(ow9[OAW-1:0]),
    .wdata(ctr_inc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ptt_pkg::S_IDLE;
      len     <= '0;
      steps   <= '0;
      op_del  <= 1'b0;
      deleted <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      o_valid <= o_valid_next;
      case (state)
        ptt_pkg::S_IDLE: begin
          if (acc) begin
            op_del  <= (in_ch.action == ptt_pkg::ACT_DEL);
            deleted <= 1'b0;
            steps   <= len;
            if (in_ch.action == ptt_pkg::ACT_SET) begin
              if (set_ok) begin
                len <= len + CW'(1);
              end
            end else if (in_ch.action == ptt_pkg::ACT_DEL ||
                         in_ch.action == ptt_pkg::ACT_TICK) begin
              if (len != '0) begin
                state <= ptt_pkg::S_WALK;
              end
            end
          end
        end
        ptt_pkg::S_WALK: begin
          if (pop) begin
            steps <= steps - CW'(1);
            if (match) begin
              len     <= lenm1;
              deleted <= 1'b1;
            end
            if (steps == CW'(1)) begin
              state <= ptt_pkg::S_FIN;
            end
          end
        end
        ptt_pkg::S_FIN: begin
          if (adv) begin
            state <= ptt_pkg::S_IDLE;
          end
        end
        default: begin
          state <= ptt_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      d_owner <= in_ch.owner;
      d_id    <= in_ch.timer_id;
    end
    if (state == ptt_pkg::S_IDLE && acc) begin
      o_kind  <= (in_ch.action == ptt_pkg::ACT_SET) ? ptt_pkg::KIND_SET :
                 (in_ch.action == ptt_pkg::ACT_DEL) ? ptt_pkg::KIND_DEL : ptt_pkg::KIND_DONE;
      o_ok    <= set_ok;
      o_owner <= 4'd0;
      o_id    <= 8'd0;
      o_mode  <= 2'd0;
      o_cnt   <= 16'd0;
      o_last  <= 1'b1;
    end else if (pop && emit) begin
      o_kind  <= ptt_pkg::KIND_EVT;
      o_ok    <= 1'b0;
      o_owner <= head.owner;
      o_id    <= head.ident;
      o_mode  <= head.mode;
      o_cnt   <= (head.mode == ptt_pkg::MODE_CTR && has_ctr) ? ctr_inc : 16'd0;
      o_last  <= 1'b0;
    end else if (state == ptt_pkg::S_FIN && adv) begin
      o_kind  <= op_del ? ptt_pkg::KIND_DEL : ptt_pkg::KIND_DONE;
      o_ok    <= op_del;
      o_owner <= 4'd0;
      o_id    <= 8'd0;
      o_mode  <= 2'd0;
      o_cnt   <= 16'd0;
      o_last  <= 1'b1;
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.kind        = o_kind;
  assign out_ch.ok          = o_ok;
  assign out_ch.event_owner = o_owner;
  assign out_ch.event_id    = o_id;
  assign out_ch.event_mode  = o_mode;
  assign out_ch.owner_count = o_cnt;
  assign out_ch.last        = o_last;

endmodule

// ----- rtl/core/ptt_checker.sv -----
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks of the periodic timer table results.
// ----------------------------------------------------------------------------
module ptt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic        ok,
  input logic [1:0]  event_mode,
  input logic [15:0] owner_count,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == ptt_pkg::KIND_SET || kind == ptt_pkg::KIND_DEL ||
                  kind == ptt_pkg::KIND_DONE) |-> last)
    else $error("status or done beat without last");

  a_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ptt_pkg::KIND_EVT |-> !last && !ok &&
      event_mode != ptt_pkg::MODE_NONE)
    else $error("malformed expiry event");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ptt_pkg::KIND_EVT && event_mode != ptt_pkg::MODE_CTR |->
      owner_count == 16'd0)
    else $error("owner count on callback event");

endmodule

bind periodic_timer_table_top ptt_checker u_ptt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .kind       (out_ch.kind),
  .ok         (out_ch.ok),
  .event_mode (out_ch.event_mode),
  .owner_count(out_ch.owner_count),
  .last       (out_ch.last)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic timer table. A directed table of
// beats covers set failures, every fire mode, delete cases and the ignored
// action. It is followed by random set/delete/tick traffic under three
// idling phases, a long result hold-off and a full drain. Every result beat
// is compared field by field with an in-bench model of the table.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] ACT_NOP     = 2'd3;
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_METHOD = 2'd1;
  localparam int         SLOTS       = ptt_pkg::TIMER_SLOTS_DEF;
  localparam int         OWNERS      = ptt_pkg::OWNER_COUNT_DEF;
  localparam int         RANDOM_BEATS = 400;
  localparam int         HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [3:0]  owner;
    logic [7:0]  ident;
    logic [1:0]  mode;
    logic [15:0] count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]  act;
    logic [3:0]  owner;
    logic [7:0]  ident;
    logic [1:0]  mode;
    logic [15:0] period;
    logic        typed;
    logic        t_ok;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptt_in_if  in_ch ();
  ptt_out_if out_ch ();

  periodic_timer_table_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // table model
  logic [3:0]  tbl_owner   [SLOTS];
  logic [7:0]  tbl_ident   [SLOTS];
  logic [1:0]  tbl_mode    [SLOTS];
  logic [14:0] tbl_period  [SLOTS];
  logic [14:0] tbl_elapsed [SLOTS];
  logic [15:0] owner_ctr   [OWNERS];
  int          tbl_used;

  result_t expected_beats[$];
  int      mismatches;
  logic    typed_now, typed_ok;
  int      send_idle_pct, recv_idle_pct;
  logic    hold_req, hold_taken;

  function automatic result_t status_beat(logic [1:0] kind, logic ok);
    result_t r;
    r = '0;
    r.kind = kind;
    r.ok   = ok;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic table_apply(logic [1:0] act, logic [3:0] owner, logic [7:0] ident,
                             logic [1:0] mode, logic [15:0] period);
    result_t r;
    logic    ok;
    int      hit;
    if (act == ptt_pkg::ACT_SET) begin
      ok = ($signed(period) > 0) && (tbl_used < SLOTS);
      if (ok) begin
        tbl_owner[tbl_used]   = owner;
        tbl_ident[tbl_used]   = ident;
        tbl_mode[tbl_used]    = mode;
        tbl_period[tbl_used]  = period[14:0];
        tbl_elapsed[tbl_used] = 15'd1;
        tbl_used++;
      end
      expected_beats.push_back(status_beat(ptt_pkg::KIND_SET, ok));
    end else if (act == ptt_pkg::ACT_DEL) begin
      ok = (tbl_used != 0);
      hit = -1;
      for (int i = 0; i < tbl_used; i++)
        if (hit < 0 && tbl_owner[i] == owner && tbl_ident[i] == ident) hit = i;
      if (hit >= 0) begin
        for (int j = hit; j + 1 < tbl_used; j++) begin
          tbl_owner[j]   = tbl_owner[j+1];
          tbl_ident[j]   = tbl_ident[j+1];
          tbl_mode[j]    = tbl_mode[j+1];
          tbl_period[j]  = tbl_period[j+1];
          tbl_elapsed[j] = tbl_elapsed[j+1];
        end
        tbl_used--;
      end
      expected_beats.push_back(status_beat(ptt_pkg::KIND_DEL, ok));
    end else if (act == ptt_pkg::ACT_TICK) begin
      for (int i = 0; i < tbl_used; i++) begin
        if (tbl_elapsed[i] == tbl_period[i]) begin
          r = '0;
          r.kind  = ptt_pkg::KIND_EVT;
          r.owner = tbl_owner[i];
          r.ident = tbl_ident[i];
          r.mode  = tbl_mode[i];
          if (tbl_mode[i] == ptt_pkg::MODE_CTR && tbl_owner[i] < OWNERS) begin
            owner_ctr[tbl_owner[i]] = owner_ctr[tbl_owner[i]] + 16'd1;
            r.count = owner_ctr[tbl_owner[i]];
          end
          if (tbl_mode[i] != ptt_pkg::MODE_NONE) expected_beats.push_back(r);
          tbl_elapsed[i] = 15'd1;
        end else begin
          tbl_elapsed[i] = tbl_elapsed[i] + 15'd1;
        end
      end
      expected_beats.push_back(status_beat(ptt_pkg::KIND_DONE, 1'b0));
    end
  endtask

  // accept input beats into the model, then check result beats
  always @(posedge clk) begin
    result_t got, want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        table_apply(in_ch.action, in_ch.owner, in_ch.timer_id, in_ch.fire_mode,
                    in_ch.period);
        if (typed_now) begin
          void'(expected_beats.pop_back());
          expected_beats.push_back(status_beat(
            in_ch.action == ptt_pkg::ACT_TICK ? ptt_pkg::KIND_DONE :
            in_ch.action == ptt_pkg::ACT_SET ? ptt_pkg::KIND_SET : ptt_pkg::KIND_DEL,
            typed_ok));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.kind, out_ch.ok, out_ch.event_owner, out_ch.event_id,
               out_ch.event_mode, out_ch.owner_count, out_ch.last};
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected kind %0d ok %0d owner %0d id %0d",
                        " mode %0d cnt %0d last %0d, got kind %0d ok %0d owner %0d",
                        " id %0d mode %0d cnt %0d last %0d"},
                       want.kind, want.ok, want.owner, want.ident, want.mode, want.count,
                       want.last, got.kind, got.ok, got.owner, got.ident, got.mode,
                       got.count, got.last);
          end
        end
      end
    end
  end

  // result side: random stall, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // valid stays up into the next call; release_bus drops it
  task automatic send_beat(row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= row.act;
    in_ch.owner     <= row.owner;
    in_ch.timer_id  <= row.ident;
    in_ch.fire_mode <= row.mode;
    in_ch.period    <= row.period;
    typed_now       <= row.typed;
    typed_ok        <= row.t_ok;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic release_bus();
    in_ch.valid <= 1'b0;
    typed_now   <= 1'b0;
  endtask

  function automatic row_t random_row();
    row_t row;
    int   pick, i;
    row = '0;
    row.owner  = 4'($urandom_range(15));
    row.ident  = 8'($urandom_range(255));
    row.mode   = 2'($urandom_range(3));
    row.period = 16'($urandom_range(1, 6));
    pick = $urandom_range(99);
    if (pick < 40) begin
      row.act = ptt_pkg::ACT_TICK;
    end else if (pick < 72) begin
      row.act = ptt_pkg::ACT_SET;
      pick = $urandom_range(19);
      if (pick == 0) row.period = 16'($urandom);
      else if (pick == 1) row.period = 16'sh7fff;
      else if (pick == 2) row.period = 16'($urandom_range(32768, 65535));
      else if (pick == 3) row.period = 16'd0;
    end else if (pick < 96) begin
      row.act = ptt_pkg::ACT_DEL;
      if (tbl_used > 0 && $urandom_range(9) < 7) begin
        i = $urandom_range(tbl_used - 1);
        row.owner = tbl_owner[i];
        row.ident = tbl_ident[i];
      end
    end else begin
      row.act = ACT_NOP;
    end
    return row;
  endfunction

  row_t directed[] = '{
    '{ptt_pkg::ACT_DEL,  4'd3,  8'd9,   MODE_PLAIN,         16'd5,    1'b1, 1'b0},
    '{ptt_pkg::ACT_TICK, 4'd0,  8'd0,   MODE_PLAIN,         16'd0,    1'b1, 1'b0},
    '{ptt_pkg::ACT_SET,  4'd1,  8'd1,   MODE_PLAIN,         16'd0,    1'b1, 1'b0},
    '{ptt_pkg::ACT_SET,  4'd1,  8'd1,   MODE_PLAIN,         16'h8000, 1'b1, 1'b0},
    '{ptt_pkg::ACT_SET,  4'd1,  8'd1,   MODE_PLAIN,         16'hffff, 1'b1, 1'b0},
    '{ptt_pkg::ACT_SET,  4'd15, 8'd255, MODE_METHOD,        16'h7fff, 1'b1, 1'b1},
    '{ptt_pkg::ACT_SET,  4'd0,  8'd0,   MODE_PLAIN,         16'd1,    1'b1, 1'b1},
    '{ptt_pkg::ACT_SET,  4'd15, 8'd170, ptt_pkg::MODE_CTR,  16'd1,    1'b1, 1'b1},
    '{ptt_pkg::ACT_SET,  4'd10, 8'd85,  ptt_pkg::MODE_NONE, 16'd1,    1'b1, 1'b1},
    '{ptt_pkg::ACT_SET,  4'd5,  8'd7,   MODE_METHOD,        16'd2,    1'b0, 1'b0},
    '{ptt_pkg::ACT_SET,  4'd5,  8'd8,   ptt_pkg::MODE_CTR,  16'd3,    1'b0, 1'b0},
    '{ptt_pkg::ACT_TICK, 4'd0,  8'd0,   MODE_PLAIN,         16'd0,    1'b0, 1'b0},
    '{ptt_pkg::ACT_TICK, 4'd0,  8'd0,   MODE_PLAIN,         16'd0,    1'b0, 1'b0},
    '{ACT_NOP,           4'd15, 8'd255, ptt_pkg::MODE_NONE, 16'hffff, 1'b0, 1'b0},
    '{ptt_pkg::ACT_TICK, 4'd0,  8'd0,   MODE_PLAIN,         16'd0,    1'b0, 1'b0},
    '{ptt_pkg::ACT_DEL,  4'd9,  8'd9,   MODE_PLAIN,         16'd0,    1'b1, 1'b1},
    '{ptt_pkg::ACT_DEL,  4'd15, 8'd170, MODE_PLAIN,         16'd0,    1'b1, 1'b1},
    '{ptt_pkg::ACT_TICK, 4'd0,  8'd0,   MODE_PLAIN,         16'd0,    1'b0, 1'b0},
    '{ptt_pkg::ACT_DEL,  4'd0,  8'd0,   MODE_PLAIN,         16'd0,    1'b1, 1'b1},
    '{ptt_pkg::ACT_TICK, 4'd0,  8'd0,   MODE_PLAIN,         16'd0,    1'b0, 1'b0},
    '{ptt_pkg::ACT_SET,  4'd15, 8'd170, ptt_pkg::MODE_CTR,  16'd1,    1'b1, 1'b1},
    '{ptt_pkg::ACT_TICK, 4'd0,  8'd0,   MODE_PLAIN,         16'd0,    1'b0, 1'b0}
  };

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    row_t row;
    in_ch.valid = 1'b0;
    in_ch.action = ptt_pkg::ACT_TICK;
    in_ch.owner = '0;
    in_ch.timer_id = '0;
    in_ch.fire_mode = '0;
    in_ch.period = '0;
    typed_now = 1'b0;
    typed_ok = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    tbl_used = 0;
    for (int i = 0; i < OWNERS; i++) owner_ctr[i] = '0;
    send_idle_pct = 7;
    recv_idle_pct = 77;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[k]) send_beat(directed[k]);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 7 : 0;
      if (phase == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < RANDOM_BEATS / 3) begin
        row = random_row();
        send_beat(row);
        if (row.act != ACT_NOP) sent++;
      end
      release_bus();
      wait_drained();
    end
    repeat (60) @(negedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
